// ----- src/cvp_pkg.sv -----
// Shared types, constants and helpers of the camera vertex projection block.
package cvp_pkg;

  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned TRIG_BITS   = 12;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned TRIG_W      = 14;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned NUM_W       = WORD_W + FRAC_BITS;
  localparam int unsigned HALF_W      = 120;
  localparam int unsigned HALF_H      = 80;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = COORD_W;

  localparam logic [WORD_W-1:0]  FIX_ONE   = WORD_W'(1 << FRAC_BITS);
  localparam logic [COORD_W-1:0] CAM_RESET = COORD_W'(1 << (FRAC_BITS - 1));
  localparam logic [TRIG_W-1:0]  TRIG_ONE  = TRIG_W'(1 << TRIG_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_YAW_SINE,
    REG_YAW_COSINE,
    REG_PITCH_SINE,
    REG_PITCH_COSINE
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_y;
    logic signed [COORD_W-1:0] camera_z;
    logic signed [TRIG_W-1:0]  yaw_sine;
    logic signed [TRIG_W-1:0]  yaw_cosine;
    logic signed [TRIG_W-1:0]  pitch_sine;
    logic signed [TRIG_W-1:0]  pitch_cosine;
  } cam_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] screen_x;
    logic signed [WORD_W-1:0] screen_y;
    logic signed [WORD_W-1:0] depth;
    logic                     zero_depth;
  } out_word_t;

  // view space point handed from the transform to the projection
  typedef struct packed {
    logic [WORD_W-1:0] x1;
    logic [WORD_W-1:0] y2;
    logic [WORD_W-1:0] z2;
  } view_t;

  function automatic logic [WORD_W-1:0] sext_coord(logic [COORD_W-1:0] v);
    return {{(WORD_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // product wrapped to 32 bits, then arithmetic shift by the trig fraction
  function automatic logic [WORD_W-1:0] trig_mul(logic [WORD_W-1:0] a,
                                                 logic [TRIG_W-1:0] b);
    logic signed [WORD_W-1:0] ae;
    logic signed [WORD_W-1:0] be;
    logic signed [WORD_W-1:0] p;
    ae = a;
    be = {{(WORD_W-TRIG_W){b[TRIG_W-1]}}, b};
    p  = ae * be;
    return p >>> TRIG_BITS;
  endfunction

endpackage

// ----- src/cvp_front.sv -----
// View transform: camera offset, yaw and pitch rotations, five stages.
module cvp_front import cvp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cam_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output view_t    out_view_o
);

  logic [4:0] v_q;
  logic       adv;

  logic [WORD_W-1:0] dx_q, dy_q, dz_q;
  logic [WORD_W-1:0] p_zs_q, p_xc_q, p_zc_q, p_xs_q, y1_s2_q;
  logic [WORD_W-1:0] x1_q, y1_q, z1_q;
  logic [WORD_W-1:0] r_yc_q, r_zs_q, r_ys_q, r_zc_q, x1_s4_q;
  view_t             view_q;

  assign adv         = ~v_q[4] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v_q[4];
  assign out_view_o  = view_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= sext_coord(in_word_i.point_x) - sext_coord(cfg_i.camera_x);
      dy_q <= sext_coord(in_word_i.point_y) - sext_coord(cfg_i.camera_y);
      dz_q <= sext_coord(in_word_i.point_z) - sext_coord(cfg_i.camera_z);

      p_zs_q  <= trig_mul(dz_q, cfg_i.yaw_sine);
      p_xc_q  <= trig_mul(dx_q, cfg_i.yaw_cosine);
      p_zc_q  <= trig_mul(dz_q, cfg_i.yaw_cosine);
      p_xs_q  <= trig_mul(dx_q, cfg_i.yaw_sine);
      y1_s2_q <= dy_q;

      x1_q <= p_zs_q + p_xc_q;
      y1_q <= y1_s2_q;
      z1_q <= p_zc_q - p_xs_q;

      r_yc_q  <= trig_mul(y1_q, cfg_i.pitch_cosine);
      r_zs_q  <= trig_mul(z1_q, cfg_i.pitch_sine);
      r_ys_q  <= trig_mul(y1_q, cfg_i.pitch_sine);
      r_zc_q  <= trig_mul(z1_q, cfg_i.pitch_cosine);
      x1_s4_q <= x1_q;

      view_q.x1 <= x1_s4_q;
      view_q.y2 <= r_yc_q - r_zs_q;
      view_q.z2 <= r_ys_q + r_zc_q;
    end
  end

endmodule

// ----- src/cvp_queue.sv -----
// Small word queue between the view transform and the projection.
module cvp_queue import cvp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  view_t data_i,
  input  logic  pop_i,
  output logic  empty_o,
  output view_t data_o
);

  view_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- src/cvp_back.sv -----
// Perspective divide (one quotient bit per stage, two lanes) and screen scaling.
module cvp_back import cvp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  view_t     in_view_i,
  output logic      empty_o,
  input  logic      pop_i,
  output out_word_t out_word_o
);

  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [NUM_W-1:0]  nq;   // numerator bits shift out the top, quotient bits in
  } div_lane_t;

  typedef struct packed {
    logic [WORD_W-1:0] den;
    logic              neg_x;
    logic              neg_y;
    logic              zero;
    logic [WORD_W-1:0] depth;
  } side_t;

  logic [NUM_W:0] dv_q;
  div_lane_t      lx_q [NUM_W+1];
  div_lane_t      ly_q [NUM_W+1];
  div_lane_t      lx_d [NUM_W+1];
  div_lane_t      ly_d [NUM_W+1];
  side_t          side_q [NUM_W+1];
  side_t          side_d;

  logic              fv_q, fzero_q;
  logic [WORD_W-1:0] sumx_q, sumy_q, fdepth_q;
  logic              ov_q;
  out_word_t         out_q;
  logic              adv;
  logic [WORD_W-1:0] ax, ay, qx, qy;

  assign adv        = ~ov_q | pop_i;
  assign in_ready_o = adv;
  assign empty_o    = ~ov_q;
  assign out_word_o = out_q;

  function automatic div_lane_t div_step(div_lane_t l, logic [WORD_W-1:0] den);
    logic [WORD_W:0] t;
    logic            ge;
    div_lane_t       r;
    t     = {l.rem, l.nq[NUM_W-1]};
    ge    = t >= {1'b0, den};
    r.rem = ge ? WORD_W'(t - {1'b0, den}) : t[WORD_W-1:0];
    r.nq  = {l.nq[NUM_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    ax = in_view_i.x1[WORD_W-1] ? -in_view_i.x1 : in_view_i.x1;
    ay = in_view_i.y2[WORD_W-1] ? -in_view_i.y2 : in_view_i.y2;
    lx_d[0] = '{rem: '0, nq: {ax, {FRAC_BITS{1'b0}}}};
    ly_d[0] = '{rem: '0, nq: {ay, {FRAC_BITS{1'b0}}}};
    side_d.den   = in_view_i.z2[WORD_W-1] ? -in_view_i.z2 : in_view_i.z2;
    side_d.neg_x = in_view_i.x1[WORD_W-1] ^ in_view_i.z2[WORD_W-1];
    side_d.neg_y = in_view_i.y2[WORD_W-1] ^ in_view_i.z2[WORD_W-1];
    side_d.zero  = in_view_i.z2 == '0;
    side_d.depth = in_view_i.z2;
    for (int k = 1; k <= NUM_W; k++) begin
      lx_d[k] = div_step(lx_q[k-1], side_q[k-1].den);
      ly_d[k] = div_step(ly_q[k-1], side_q[k-1].den);
    end
  end

  assign qx = side_q[NUM_W].neg_x ? -lx_q[NUM_W].nq[WORD_W-1:0]
                                  : lx_q[NUM_W].nq[WORD_W-1:0];
  assign qy = side_q[NUM_W].neg_y ? -ly_q[NUM_W].nq[WORD_W-1:0]
                                  : ly_q[NUM_W].nq[WORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      fv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      dv_q <= {dv_q[NUM_W-1:0], in_valid_i};
      fv_q <= dv_q[NUM_W];
      ov_q <= fv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= NUM_W; k++) begin
        lx_q[k] <= lx_d[k];
        ly_q[k] <= ly_d[k];
      end
      side_q[0] <= side_d;
      for (int k = 1; k <= NUM_W; k++) begin
        side_q[k] <= side_q[k-1];
      end

      sumx_q   <= qx + FIX_ONE;
      sumy_q   <= qy + FIX_ONE;
      fzero_q  <= side_q[NUM_W].zero;
      fdepth_q <= side_q[NUM_W].depth;

      out_q.screen_x   <= fzero_q ? '0 : sumx_q * WORD_W'(HALF_W);
      out_q.screen_y   <= fzero_q ? '0 : sumy_q * WORD_W'(HALF_H);
      out_q.depth      <= fdepth_q;
      out_q.zero_depth <= fzero_q;
    end
  end

endmodule

// ----- src/camera_vertex_project.sv -----
// Top level: configuration registers, view transform, queue and projection.
//
// Takes one world point per cycle while full is low and gives one screen word
// per cycle while pop is high. A word passes the view transform stages and
// the 4-word queue, then a setup register, 44 divide stages (one quotient bit
// per stage, x and y in parallel lanes), an offset register and a scaling
// register before it shows on the result ports. The transform and the
// projection stall independently; push sees full only when the transform's
// last stage holds a word and the queue is full. Configuration is taken every
// cycle (cfg_ready_o is always high) and must be written while no point is in
// flight.
module camera_vertex_project import cvp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_word_t              in_word_i,
  input  logic                  pop,
  output logic                  empty,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cam_cfg_t cfg_q;
  logic     front_ready, front_valid;
  view_t    front_view;
  logic     q_full, q_empty, back_ready;
  view_t    q_view;

  assign cfg_ready_o = 1'b1;
  assign full        = ~front_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x     <= CAM_RESET;
      cfg_q.camera_y     <= CAM_RESET;
      cfg_q.camera_z     <= CAM_RESET;
      cfg_q.yaw_sine     <= '0;
      cfg_q.yaw_cosine   <= TRIG_ONE;
      cfg_q.pitch_sine   <= '0;
      cfg_q.pitch_cosine <= TRIG_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CAMERA_X:     cfg_q.camera_x     <= cfg_data_i;
        REG_CAMERA_Y:     cfg_q.camera_y     <= cfg_data_i;
        REG_CAMERA_Z:     cfg_q.camera_z     <= cfg_data_i;
        REG_YAW_SINE:     cfg_q.yaw_sine     <= cfg_data_i[TRIG_W-1:0];
        REG_YAW_COSINE:   cfg_q.yaw_cosine   <= cfg_data_i[TRIG_W-1:0];
        REG_PITCH_SINE:   cfg_q.pitch_sine   <= cfg_data_i[TRIG_W-1:0];
        REG_PITCH_COSINE: cfg_q.pitch_cosine <= cfg_data_i[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  cvp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .in_word_i   (in_word_i),
    .out_valid_o (front_valid),
    .out_ready_i (~q_full),
    .out_view_o  (front_view)
  );

  cvp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .full_o  (q_full),
    .data_i  (front_view),
    .pop_i   (back_ready),
    .empty_o (q_empty),
    .data_o  (q_view)
  );

  cvp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (~q_empty),
    .in_ready_o (back_ready),
    .in_view_i  (q_view),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );

`ifndef NO_ASSERTIONS
  zero_depth_clears_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.zero_depth) |->
      (out_word_o.screen_x == '0 && out_word_o.screen_y == '0))
    else $error("zero depth word with nonzero screen position");

  zero_flag_matches_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_word_o.zero_depth == (out_word_o.depth == '0)))
    else $error("zero depth flag disagrees with depth");

  camera_x_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_CAMERA_X) |=>
      (cfg_q.camera_x == $past(cfg_data_i)))
    else $error("camera x register not updated by write");
`endif

endmodule
